@@ sv/pdomq_pkg.sv @@
// Shared types, constants and helpers for the paced drop-oldest message queue.
package pdomq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = FILL_W + 1;
    localparam int REM_W       = 4;
    localparam int REM_MAX     = (QUEUE_DEPTH - 1 < 15) ? QUEUE_DEPTH - 1 : 15;
    localparam int GAP_W       = 16;
    localparam int ECHO_W      = 32;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd1000;

    // Word index of each configuration register (byte address bit 2).
    localparam logic REG_MIN_GAP = 1'b0;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_ENQUEUE = 2'd1,
        FUNC_REARM   = 2'd2
    } t_func;

    typedef struct packed {
        logic              motion;
        logic [9:0]        light;
        logic signed [15:0] time_stamp;
        logic [7:0]        type_code;
    } t_msg_main;

    typedef struct packed {
        logic push;
        logic pop;
    } t_store_ctrl;

    typedef struct packed {
        logic tick;
        logic rearm;
    } t_pace_ctrl;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

@@ sv/pdomq_apb.sv @@
// APB-style configuration register holding the minimum send gap.
module pdomq_apb (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdomq_pkg::APB_AW-1:0] paddr,
    input  logic [pdomq_pkg::APB_DW-1:0] pwdata,
    output logic [pdomq_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output logic [pdomq_pkg::GAP_W-1:0]  o_gap
);
    import pdomq_pkg::*;

    logic [GAP_W-1:0] r_gap;
    logic [GAP_W-1:0] n_gap;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        n_gap = r_gap;
        if (wr_en && (paddr[2] == REG_MIN_GAP)) begin
            n_gap = pwdata[GAP_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_GAP: prdata = APB_DW'(r_gap);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else begin
            r_gap <= n_gap;
        end
    end

    assign o_gap = r_gap;

endmodule

@@ sv/pdomq_store.sv @@
// Ring buffer of queued messages with head pointer and fill count.
module pdomq_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pdomq_pkg::t_store_ctrl        i_ctrl,
    input  pdomq_pkg::t_msg_main          i_main,
    input  logic [pdomq_pkg::ECHO_W-1:0]  i_echo,
    output pdomq_pkg::t_msg_main          o_head_main,
    output logic [pdomq_pkg::ECHO_W-1:0]  o_head_echo,
    output logic [pdomq_pkg::FILL_W-1:0]  o_fill
);
    import pdomq_pkg::*;

    t_msg_main         r_slot_main [QUEUE_DEPTH];
    logic [ECHO_W-1:0] r_slot_echo [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_head;
    logic [FILL_W-1:0] r_fill;
    logic [PTR_W-1:0]  n_head;
    logic [FILL_W-1:0] n_fill;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  wr_addr;
    logic              full;

    assign full     = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_fill);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    // A full queue overwrites its oldest slot, which is the head.
    assign wr_addr  = full ? r_head : tail;

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_ctrl.push) begin
            if (full) begin
                n_head = next_ptr(r_head);
            end else begin
                n_fill = r_fill + 1'b1;
            end
        end else if (i_ctrl.pop && (r_fill != '0)) begin
            n_head = next_ptr(r_head);
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_slot_main[wr_addr] <= i_main;
            r_slot_echo[wr_addr] <= i_echo;
        end
    end

    assign o_head_main = r_slot_main[r_head];
    assign o_head_echo = r_slot_echo[r_head];
    assign o_fill      = r_fill;

endmodule

@@ sv/pdomq_pacer.sv @@
// Send pacing: saturating elapsed-tick counter and the sent-since-rearm flag.
module pdomq_pacer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pdomq_pkg::t_pace_ctrl       i_ctrl,
    input  logic                        i_not_empty,
    input  logic [pdomq_pkg::GAP_W-1:0] i_gap,
    output logic                        o_send
);
    import pdomq_pkg::*;

    logic [GAP_W-1:0] r_elapsed;
    logic             r_sent;
    logic [GAP_W-1:0] n_elapsed;
    logic             n_sent;
    logic [GAP_W-1:0] bumped;

    // The counter only climbs while below the gap, so the increment cannot wrap.
    assign bumped = (r_elapsed < i_gap) ? r_elapsed + 1'b1 : r_elapsed;
    assign o_send = i_ctrl.tick && i_not_empty && (!r_sent || (bumped >= i_gap));

    always_comb begin
        n_elapsed = r_elapsed;
        n_sent    = r_sent;
        if (i_ctrl.tick) begin
            n_elapsed = o_send ? '0 : bumped;
            if (o_send) begin
                n_sent = 1'b1;
            end
        end else if (i_ctrl.rearm) begin
            n_sent = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_sent    <= 1'b0;
        end else begin
            r_elapsed <= n_elapsed;
            r_sent    <= n_sent;
        end
    end

endmodule

@@ sv/paced_drop_oldest_message_queue_top.sv @@
// Top level of the paced drop-oldest message queue.
//
// The block keeps up to QUEUE_DEPTH alarm messages in a ring buffer. Each input
// item is a tick, an enqueue or a rearm request, chosen by i_func; the unused
// code is ignored. An enqueue into a full queue silently drops the oldest
// message. A tick advances a millisecond counter that saturates at min_gap_ms,
// and sends the head message as one result item when the queue holds something
// and either nothing has been sent since the last rearm or the gap has passed;
// o_remaining then tells how many messages are still queued. Every input item
// is registered, handled in a single pass over the ring pointers and the
// pacing compare, and any result is registered on the output side, so the
// block takes one item per cycle while the output is not stalled. The message
// store needs no clearing after reset: only slots holding queued messages are
// ever read. min_gap_ms lives at byte address 0 of the APB-style port, resets
// to 1000 and should only be written while the block is idle.
module paced_drop_oldest_message_queue_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdomq_pkg::APB_AW-1:0] paddr,
    input  logic [pdomq_pkg::APB_DW-1:0] pwdata,
    output logic [pdomq_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    // Input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_func,
    input  logic [7:0]                   i_type_code,
    input  logic signed [15:0]           i_time_stamp,
    input  logic [9:0]                   i_light_level,
    input  logic [31:0]                  i_echo_value,
    input  logic                         i_motion_seen,
    // Output channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_out_type,
    output logic signed [15:0]           o_out_time_stamp,
    output logic [9:0]                   o_out_light_level,
    output logic [31:0]                  o_out_echo_value,
    output logic                         o_out_motion,
    output logic [3:0]                   o_remaining
);
    import pdomq_pkg::*;

    // Input register: holds one accepted item until it has been handled.
    logic              r_in_valid;
    logic [1:0]        r_func;
    t_msg_main         r_main;
    logic [ECHO_W-1:0] r_echo;

    // Result register.
    logic              r_out_valid;
    t_msg_main         r_out_main;
    logic [ECHO_W-1:0] r_out_echo;
    logic [REM_W-1:0]  r_out_rem;

    logic              in_accept;
    logic              advance;
    logic              send;
    logic [GAP_W-1:0]  gap;
    t_store_ctrl       store_ctrl;
    t_pace_ctrl        pace_ctrl;
    t_msg_main         head_main;
    logic [ECHO_W-1:0] head_echo;
    logic [FILL_W-1:0] fill;
    logic [REM_W-1:0]  n_remaining;

    // The held item is handled whenever the result register is free or is
    // being emptied in the same cycle, so the input only stalls behind a
    // stalled result.
    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_comb begin
        store_ctrl = '0;
        pace_ctrl  = '0;
        if (advance) begin
            unique case (t_func'(r_func))
                FUNC_TICK:    pace_ctrl.tick   = 1'b1;
                FUNC_ENQUEUE: store_ctrl.push  = 1'b1;
                FUNC_REARM:   pace_ctrl.rearm  = 1'b1;
                default:      pace_ctrl        = '0;
            endcase
        end
        store_ctrl.pop = send;
    end

    pdomq_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gap   (gap)
    );

    pdomq_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (store_ctrl),
        .i_main      (r_main),
        .i_echo      (r_echo),
        .o_head_main (head_main),
        .o_head_echo (head_echo),
        .o_fill      (fill)
    );

    pdomq_pacer u_pacer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (pace_ctrl),
        .i_not_empty (fill != '0),
        .i_gap       (gap),
        .o_send      (send)
    );

    // A send only happens on a non-empty queue, so this never underflows.
    assign n_remaining = REM_W'(fill - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (send) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func           <= i_func;
            r_main.type_code <= i_type_code;
            r_main.time_stamp <= i_time_stamp;
            r_main.light     <= i_light_level;
            r_main.motion    <= i_motion_seen;
            r_echo           <= i_echo_value;
        end
        if (send) begin
            r_out_main <= head_main;
            r_out_echo <= head_echo;
            r_out_rem  <= n_remaining;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_out_type        = r_out_main.type_code;
    assign o_out_time_stamp  = r_out_main.time_stamp;
    assign o_out_light_level = r_out_main.light;
    assign o_out_echo_value  = r_out_echo;
    assign o_out_motion      = r_out_main.motion;
    assign o_remaining       = r_out_rem;

endmodule

@@ sv/pdomq_checker.sv @@
// Port-level checker for the paced drop-oldest message queue, with its bind.
module pdomq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [7:0]                   o_out_type,
    input logic signed [15:0]           o_out_time_stamp,
    input logic [9:0]                   o_out_light_level,
    input logic [31:0]                  o_out_echo_value,
    input logic                         o_out_motion,
    input logic [3:0]                   o_remaining
);
    import pdomq_pkg::*;

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // The input only stalls behind a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a stalled result");

    // A sent message leaves at most one fewer than a full queue behind.
    a_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_remaining <= REM_W'(REM_MAX)))
        else $error("remaining count out of range");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_type)
            && $stable(o_out_time_stamp) && $stable(o_out_light_level)
            && $stable(o_out_echo_value) && $stable(o_out_motion)
            && $stable(o_remaining)))
        else $error("stalled result changed");

endmodule

bind paced_drop_oldest_message_queue_top pdomq_checker u_pdomq_checker (.*);
